### design/bsa_pkg.sv
package bsa_pkg;

   localparam int SLOTS_DEF  = 64;
   localparam int CHUNK      = 8;   // bitmap bits per memory word
   localparam int CHUNK_BITS = 3;
   localparam int ACTION_W   = 3;
   localparam int SLOT_W     = 6;
   localparam int STATUS_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_NEXT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PREV  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_RD,
      S_FREE_CK,
      S_SCAN_CK,
      S_RESP
   } state_type;

endpackage

### design/bsa_req_if.sv
interface bsa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsa_pkg::ACTION_W-1:0]  action;
   logic [bsa_pkg::SLOT_W-1:0]    slot;

   modport source (output valid, action, slot, input ready);
   modport sink   (input valid, action, slot, output ready);
endinterface

### design/bsa_rsp_if.sv
interface bsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsa_pkg::SLOT_W-1:0]    result_slot;
   logic [bsa_pkg::STATUS_W-1:0]  status;
   logic [bsa_pkg::SLOT_W-1:0]    lowest_taken;
   logic [bsa_pkg::SLOT_W-1:0]    highest_taken;
   logic                          is_empty;

   modport source (output valid, result_slot, status, lowest_taken, highest_taken, is_empty,
                   input ready);
   modport sink   (input valid, result_slot, status, lowest_taken, highest_taken, is_empty,
                   output ready);
endinterface

### design/bitmap_slot_allocator_top.sv
// One operation at a time. With W = ceil(SLOTS/8) bitmap words, allocate/next/prev scan the
// bitmap one memory word per cycle, free reads one word and may rescan to move a mark, clear
// sweeps the words one per cycle, and a full map, a bad slot, a search off either end or an
// unused action go straight to the result beat. Throughput: one request per result beat
// taken, paced by the word scan. Synchronous reset; afterwards all W words of the bitmap
// memory are swept to zero, with req_ch.ready low.
module bitmap_slot_allocator_top #(
   parameter int SLOTS = bsa_pkg::SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bsa_req_if.sink   req_ch,
   bsa_rsp_if.source rsp_ch
);

   localparam int CB = bsa_pkg::CHUNK_BITS;
   localparam int CK = bsa_pkg::CHUNK;
   localparam int W  = (SLOTS + bsa_pkg::CHUNK - 1) / bsa_pkg::CHUNK;
   localparam int AW = (W > 1) ? $clog2(W) : 1;
   localparam int PW = AW + CB;               // word address plus bit offset
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [AW-1:0] LAST = AW'(W - 1);

   // bitmap store, eight slots a word
   logic [CK-1:0] mem [W];
   logic [CK-1:0] rd_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [CK-1:0] wdata;

   bsa_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                  cur_ff, cur_in;     // word under the scan
   logic [CB-1:0]                  sbit_ff, sbit_in;   // start bit in the first word
   logic                           first_ff, first_in;
   logic                           up_ff, up_in;       // scan direction
   logic                           free_ff, free_in;   // hunt for a clear bit (allocate)
   logic                           rescan_ff, rescan_in; // mark rebuild after a free
   logic                           pend_ff, pend_in;   // sweep owes a clear response
   logic [bsa_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [AW-1:0]                  sweep_ff, sweep_in;
   logic [CW-1:0]                  count_ff, count_in; // taken slots
   logic [IW-1:0]                  low_ff, low_in;
   logic [IW-1:0]                  high_ff, high_in;
   logic [bsa_pkg::SLOT_W-1:0]     res_ff, res_in;
   logic [bsa_pkg::STATUS_W-1:0]   stat_ff, stat_in;

   // request decode
   logic          slot_ok;
   logic [PW-1:0] sl;
   logic [PW:0]   nxt;
   logic [PW-1:0] prv;

   // word scan
   logic [CK-1:0] look, cand, smask;
   logic          hit, last;
   logic [CB-1:0] hbit;
   logic [PW-1:0] hpos, spos, spos_up, spos_dn;

   assign slot_ok = 32'(req_ch.slot) < 32'(SLOTS);
   assign sl      = PW'(req_ch.slot);
   assign nxt     = {1'b0, sl} + 1'b1;
   assign prv     = sl - 1'b1;

   assign spos    = {cur_ff, sbit_ff};
   assign spos_up = spos + 1'b1;
   assign spos_dn = spos - 1'b1;
   assign smask   = CK'(1) << sbit_ff;

   always_comb begin
      look = free_ff ? ~rd_ff : rd_ff;
      for (int b = 0; b < CK; b++) begin
         // bits past the last slot never count; first word is cut at the start bit
         cand[b] = look[b] && ({1'b0, cur_ff, CB'(b)} < (PW + 1)'(SLOTS));
         if (first_ff) begin
            if (up_ff) begin
               cand[b] = cand[b] && (CB'(b) >= sbit_ff);
            end else begin
               cand[b] = cand[b] && (CB'(b) <= sbit_ff);
            end
         end
      end
   end

   always_comb begin
      hbit = '0;
      if (up_ff) begin
         for (int b = CK - 1; b >= 0; b--) begin
            if (cand[b]) begin
               hbit = CB'(b);
            end
         end
      end else begin
         for (int b = 0; b < CK; b++) begin
            if (cand[b]) begin
               hbit = CB'(b);
            end
         end
      end
   end

   assign hit  = |cand;
   assign hpos = {cur_ff, hbit};
   assign last = up_ff ? (cur_ff == LAST) : (cur_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsa_pkg::S_SWEEP: begin
            if (sweep_ff == LAST) begin
               state_in = pend_ff ? bsa_pkg::S_RESP : bsa_pkg::S_IDLE;
            end
         end
         bsa_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.action)
                  bsa_pkg::ACT_ALLOC: begin
                     state_in = (count_ff == CW'(SLOTS)) ? bsa_pkg::S_RESP : bsa_pkg::S_RD;
                  end
                  bsa_pkg::ACT_FREE: begin
                     state_in = slot_ok ? bsa_pkg::S_RD : bsa_pkg::S_RESP;
                  end
                  bsa_pkg::ACT_CLEAR: begin
                     state_in = bsa_pkg::S_SWEEP;
                  end
                  bsa_pkg::ACT_NEXT: begin
                     state_in = (slot_ok && nxt < (PW + 1)'(SLOTS)) ?
                                bsa_pkg::S_RD : bsa_pkg::S_RESP;
                  end
                  bsa_pkg::ACT_PREV: begin
                     state_in = (slot_ok && sl != '0) ? bsa_pkg::S_RD : bsa_pkg::S_RESP;
                  end
                  default: begin
                     state_in = bsa_pkg::S_RESP;
                  end
               endcase
            end
         end
         bsa_pkg::S_RD: begin
            state_in = (act_ff == bsa_pkg::ACT_FREE && !rescan_ff) ?
                       bsa_pkg::S_FREE_CK : bsa_pkg::S_SCAN_CK;
         end
         bsa_pkg::S_FREE_CK: begin
            if (rd_ff[sbit_ff] && count_ff != CW'(1) &&
                (spos == PW'(low_ff) || spos == PW'(high_ff))) begin
               state_in = bsa_pkg::S_RD;
            end else begin
               state_in = bsa_pkg::S_RESP;
            end
         end
         bsa_pkg::S_SCAN_CK: begin
            if (hit || last) begin
               state_in = bsa_pkg::S_RESP;
            end
         end
         bsa_pkg::S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = bsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in    = cur_ff;
      sbit_in   = sbit_ff;
      first_in  = first_ff;
      up_in     = up_ff;
      free_in   = free_ff;
      rescan_in = rescan_ff;
      pend_in   = pend_ff;
      act_in    = act_ff;
      sweep_in  = sweep_ff;
      count_in  = count_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      we        = 1'b0;
      waddr     = cur_ff;
      wdata     = rd_ff;
      unique case (state_ff)
         bsa_pkg::S_SWEEP: begin
            we    = 1'b1;
            waddr = sweep_ff;
            wdata = '0;
            if (sweep_ff == LAST) begin
               sweep_in = '0;
               pend_in  = 1'b0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         bsa_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               act_in    = req_ch.action;
               rescan_in = 1'b0;
               res_in    = '0;
               stat_in   = bsa_pkg::STAT_DONE;
               first_in  = 1'b1;
               free_in   = 1'b0;
               up_in     = 1'b1;
               cur_in    = sl[PW-1:CB];
               sbit_in   = sl[CB-1:0];
               unique case (req_ch.action)
                  bsa_pkg::ACT_ALLOC: begin
                     if (count_ff == CW'(SLOTS)) begin
                        stat_in = bsa_pkg::STAT_NONE;
                     end else begin
                        cur_in  = '0;
                        sbit_in = '0;
                        free_in = 1'b1;
                     end
                  end
                  bsa_pkg::ACT_FREE: begin
                     if (!slot_ok) begin
                        stat_in = bsa_pkg::STAT_BAD;
                     end
                  end
                  bsa_pkg::ACT_CLEAR: begin
                     pend_in  = 1'b1;
                     sweep_in = '0;
                     count_in = '0;
                     low_in   = '0;
                     high_in  = '0;
                  end
                  bsa_pkg::ACT_NEXT: begin
                     if (!slot_ok) begin
                        stat_in = bsa_pkg::STAT_BAD;
                     end else if (nxt >= (PW + 1)'(SLOTS)) begin
                        stat_in = bsa_pkg::STAT_NONE;
                     end else begin
                        cur_in  = nxt[PW-1:CB];
                        sbit_in = nxt[CB-1:0];
                     end
                  end
                  bsa_pkg::ACT_PREV: begin
                     if (!slot_ok) begin
                        stat_in = bsa_pkg::STAT_BAD;
                     end else if (sl == '0) begin
                        stat_in = bsa_pkg::STAT_NONE;
                     end else begin
                        cur_in  = prv[PW-1:CB];
                        sbit_in = prv[CB-1:0];
                        up_in   = 1'b0;
                     end
                  end
                  default: begin
                     stat_in = bsa_pkg::STAT_BAD;
                  end
               endcase
            end
         end
         bsa_pkg::S_RD: begin
            // read of cur_ff is under way
         end
         bsa_pkg::S_FREE_CK: begin
            if (!rd_ff[sbit_ff]) begin
               stat_in = bsa_pkg::STAT_BAD;
            end else begin
               we       = 1'b1;
               wdata    = rd_ff & ~smask;
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  low_in  = '0;
                  high_in = '0;
               end else if (spos == PW'(low_ff)) begin
                  // lowest went away: find the next taken slot above
                  rescan_in = 1'b1;
                  first_in  = 1'b1;
                  up_in     = 1'b1;
                  cur_in    = spos_up[PW-1:CB];
                  sbit_in   = spos_up[CB-1:0];
               end else if (spos == PW'(high_ff)) begin
                  rescan_in = 1'b1;
                  first_in  = 1'b1;
                  up_in     = 1'b0;
                  cur_in    = spos_dn[PW-1:CB];
                  sbit_in   = spos_dn[CB-1:0];
               end
            end
         end
         bsa_pkg::S_SCAN_CK: begin
            if (hit) begin
               if (rescan_ff) begin
                  if (up_ff) begin
                     low_in = IW'(hpos);
                  end else begin
                     high_in = IW'(hpos);
                  end
               end else if (free_ff) begin
                  we       = 1'b1;
                  wdata    = rd_ff | (CK'(1) << hbit);
                  count_in = count_ff + 1'b1;
                  res_in   = bsa_pkg::SLOT_W'(hpos);
                  if (count_ff == '0) begin
                     low_in  = IW'(hpos);
                     high_in = IW'(hpos);
                  end else begin
                     if (hpos < PW'(low_ff)) begin
                        low_in = IW'(hpos);
                     end
                     if (hpos > PW'(high_ff)) begin
                        high_in = IW'(hpos);
                     end
                  end
               end else begin
                  res_in = bsa_pkg::SLOT_W'(hpos);
               end
            end else if (last) begin
               stat_in = bsa_pkg::STAT_NONE;
            end else begin
               cur_in   = up_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
               first_in = 1'b0;
            end
         end
         bsa_pkg::S_RESP: begin
            // result beat held until taken
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   assign req_ch.ready         = (state_ff == bsa_pkg::S_IDLE);
   assign rsp_ch.valid         = (state_ff == bsa_pkg::S_RESP);
   assign rsp_ch.result_slot   = res_ff;
   assign rsp_ch.status        = stat_ff;
   assign rsp_ch.lowest_taken  = bsa_pkg::SLOT_W'(low_ff);
   assign rsp_ch.highest_taken = bsa_pkg::SLOT_W'(high_ff);
   assign rsp_ch.is_empty      = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read-before-write: a read in the same cycle as a write to that word returns the old contents
   always_ff @(posedge clock) begin
      rd_ff <= mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::S_SWEEP;
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      sbit_ff   <= sbit_in;
      first_ff  <= first_in;
      up_ff     <= up_in;
      free_ff   <= free_in;
      rescan_ff <= rescan_in;
      act_ff    <= act_in;
      res_ff    <= res_in;
      stat_ff   <= stat_in;
   end

endmodule
